@@ rtl/oabs_pkg.sv @@
// ----------------------------------------------------------------------------
// Order-agnostic binary search package
// Shared widths, codes and types for the search core and its submodules.
// ----------------------------------------------------------------------------
package oabs_pkg;

   localparam int WORD_W        = 32;
   localparam int INDEX_W       = 10;
   localparam int DEPTH_DEFAULT = 1024;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [INDEX_W-1:0]       index_type;

   // Item opcodes carried on the mode field.
   typedef enum logic {
      MODE_LOAD   = 1'b0,
      MODE_SEARCH = 1'b1
   } mode_type;

endpackage

@@ rtl/oabs_ram.sv @@
// ----------------------------------------------------------------------------
// Element memory
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module oabs_ram
   import oabs_pkg::*;
#(
   parameter  int DEPTH  = DEPTH_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  word_type          wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output word_type          rd_data
);

   word_type mem [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/oabs_seq.sv @@
// ----------------------------------------------------------------------------
// Search sequencer
// Keeps the element count, writes loaded items and walks the bisection one
// memory probe per cycle with a single shared compare unit.
// ----------------------------------------------------------------------------
module oabs_seq
   import oabs_pkg::*;
#(
   parameter  int DEPTH   = DEPTH_DEFAULT,
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int COUNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_mode,
   input  logic              req_first_element,
   input  word_type          req_element_value,
   input  word_type          req_search_key,
   output logic              rsp_strobe,
   output logic              rsp_found,
   output index_type         rsp_found_index,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output word_type          wr_data,
   output logic [ADDR_W-1:0] rd_addr,
   input  word_type          rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_PROBE
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]    lo_ff, lo_in;
   logic [ADDR_W-1:0]    hi_ff, hi_in;
   logic [ADDR_W-1:0]    mid_ff, mid_in;
   word_type             key_ff, key_in;
   word_type             first_word_ff, first_word_in;
   logic                 desc_ff, desc_in;
   logic                 strobe_ff, strobe_in;
   logic                 found_ff, found_in;
   index_type            index_ff, index_in;

   logic                 accept;
   logic [COUNT_W-1:0]   load_base;
   logic [ADDR_W-1:0]    mid_dn, mid_up, nmid_dn, nmid_up;
   logic                 key_eq, key_lt, go_down;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Both possible next midpoints are formed alongside the compare.
   assign mid_dn  = mid_ff - ADDR_W'(1);
   assign mid_up  = mid_ff + ADDR_W'(1);
   assign nmid_dn = lo_ff + ((mid_dn - lo_ff) >> 1);
   assign nmid_up = mid_up + ((hi_ff - mid_up) >> 1);

   assign key_eq  = (key_ff == rd_data);
   assign key_lt  = (key_ff < rd_data);
   assign go_down = (key_lt != desc_ff);

   assign load_base = req_first_element ? '0 : count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      key_in        = key_ff;
      first_word_in = first_word_ff;
      desc_in       = desc_ff;
      strobe_in     = 1'b0;
      found_in      = 1'b0;
      index_in      = '0;
      wr_en         = 1'b0;
      wr_addr       = load_base[ADDR_W-1:0];
      wr_data       = req_element_value;
      rd_addr       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_LOAD) begin
                  // A word loaded into a full array is dropped.
                  if (load_base < COUNT_W'(DEPTH)) begin
                     wr_en    = 1'b1;
                     count_in = load_base + COUNT_W'(1);
                  end else begin
                     count_in = load_base;
                  end
               end else if (count_ff == '0) begin
                  strobe_in = 1'b1;
               end else begin
                  key_in   = req_search_key;
                  lo_in    = '0;
                  hi_in    = ADDR_W'(count_ff - COUNT_W'(1));
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            first_word_in = rd_data;
            rd_addr       = hi_ff;
            state_in      = ST_LAST;
         end
         ST_LAST: begin
            // Equal end words are treated as ascending.
            desc_in  = (first_word_ff > rd_data);
            mid_in   = hi_ff >> 1;
            rd_addr  = hi_ff >> 1;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (key_eq) begin
               strobe_in = 1'b1;
               found_in  = 1'b1;
               index_in  = INDEX_W'(mid_ff);
               state_in  = ST_IDLE;
            end else if (go_down) begin
               if (mid_ff == lo_ff) begin
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  hi_in   = mid_dn;
                  mid_in  = nmid_dn;
                  rd_addr = nmid_dn;
               end
            end else begin
               if (mid_ff == hi_ff) begin
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  lo_in   = mid_up;
                  mid_in  = nmid_up;
                  rd_addr = nmid_up;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         found_ff  <= 1'b0;
         index_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         found_ff  <= found_in;
         index_ff  <= index_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      key_ff        <= key_in;
      first_word_ff <= first_word_in;
      desc_ff       <= desc_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_found       = found_ff;
   assign rsp_found_index = index_ff;

endmodule

@@ rtl/order_agnostic_binary_search_core.sv @@
// ----------------------------------------------------------------------------
// Order-agnostic binary search core
// Loads a sorted array of signed words and answers search keys over it.
// ----------------------------------------------------------------------------
// A load item leaves busy low and produces no result.
// A search over n loaded words holds busy while the first and last words are read
// and then for p probes, at most ceil(log2(n + 1)), one memory read per probe.
// The result strobe is registered after the final probe and the receiver cannot
// stall it; a search of an empty array answers without raising busy.
// Reset clears the element count and sequencer; memory contents are kept.
module order_agnostic_binary_search_core
   import oabs_pkg::*;
#(
   parameter  int DEPTH  = DEPTH_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  logic      req_mode,
   input  logic      req_first_element,
   input  word_type  req_element_value,
   input  word_type  req_search_key,
   output logic      rsp_strobe,
   output logic      rsp_found,
   output index_type rsp_found_index
);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   word_type          wr_data;
   logic [ADDR_W-1:0] rd_addr;
   word_type          rd_data;

   oabs_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_first_element (req_first_element),
      .req_element_value (req_element_value),
      .req_search_key    (req_search_key),
      .rsp_strobe        (rsp_strobe),
      .rsp_found         (rsp_found),
      .rsp_found_index   (rsp_found_index),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data)
   );

   oabs_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

`ifndef SYNTHESIS
   // A result only appears once the sequencer has returned to idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // A miss always reports index zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> (rsp_found_index == '0))
      else $error("miss with nonzero index");

   // A load item never starts a search and never produces a result.
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == MODE_LOAD)) |=> (!busy && !rsp_strobe))
      else $error("load item produced activity");
`endif

endmodule

@@ tb/oabs_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search result checker
// Watches the item and result channels of the search core. It keeps its own
// copy of the loaded array, bisects it for every accepted search item, and
// compares each result strobe with the oldest outstanding lookup.
// ----------------------------------------------------------------------------
module oabs_result_checker
   import oabs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      busy,
   input  logic      req_mode,
   input  logic      req_first_element,
   input  word_type  req_element_value,
   input  word_type  req_search_key,
   input  logic      rsp_strobe,
   input  logic      rsp_found,
   input  index_type rsp_found_index,
   output int        pending,
   output int        fail_count,
   output int        hit_count
);

   typedef struct packed {
      logic      found;
      index_type index;
   } lookup_type;

   word_type    array_copy [DEPTH];
   int unsigned loaded_count = 0;
   lookup_type  expected_lookups [$];
   int          mismatches = 0;
   int          hits = 0;

   // The order of the array is decided from its end words on every search.
   function automatic lookup_type lookup_key(word_type key);
      lookup_type result;
      longint     low;
      longint     high;
      longint     mid;
      logic       descending;
      result = '{found: 1'b0, index: '0};
      if (loaded_count == 0) return result;
      low        = 0;
      high       = longint'(loaded_count) - 1;
      descending = array_copy[0] > array_copy[high];
      while (low <= high) begin
         mid = low + (high - low) / 2;
         if (key == array_copy[mid]) begin
            result.found = 1'b1;
            result.index = index_type'(mid);
            return result;
         end
         if ((key < array_copy[mid]) != descending) high = mid - 1;
         else low = mid + 1;
      end
      return result;
   endfunction

   function automatic void flag_mismatch(string what, lookup_type want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected found=%0b index=%0d, got found=%0b index=%0d",
                  $time, what, want.found, want.index, rsp_found, rsp_found_index);
      end
   endfunction

   always @(posedge clock) begin
      lookup_type want;
      if (reset) begin
         loaded_count = 0;
         expected_lookups.delete();
      end else begin
         // A result at this edge always belongs to an item accepted earlier.
         if (rsp_strobe !== 1'b0) begin
            if (expected_lookups.size() == 0) begin
               flag_mismatch("result with no search outstanding", '0);
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_strobe !== 1'b1 || rsp_found !== want.found ||
                   rsp_found_index !== want.index) begin
                  flag_mismatch("search result mismatch", want);
               end else if (want.found) begin
                  hits++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            if (req_mode == MODE_LOAD) begin
               if (req_first_element) loaded_count = 0;
               if (loaded_count < DEPTH) begin
                  array_copy[loaded_count] = req_element_value;
                  loaded_count++;
               end
            end else begin
               expected_lookups.push_back(lookup_key(req_search_key));
            end
         end
      end
      pending    <= expected_lookups.size();
      fail_count <= mismatches;
      hit_count  <= hits;
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order-agnostic binary search core testbench
// Loads sorted, flat, clustered and unsorted arrays of both orders, searches
// them with present, neighboring, extreme and random keys under random sender
// gaps, and fills the whole store past its end. A checker module predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import oabs_pkg::*;

   localparam int          DEPTH        = DEPTH_DEFAULT;
   localparam int          RANDOM_ITEMS = 80;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam word_type    WORD_MIN     = 32'sh8000_0000;
   localparam word_type    WORD_MAX     = 32'sh7fff_ffff;

   typedef enum {
      FILL_SPREAD,
      FILL_CLUSTERED,
      FILL_FLAT,
      FILL_EXTREMES,
      FILL_UNSORTED
   } fill_kind_type;

   logic      clock             = 1'b0;
   logic      reset             = 1'b1;
   logic      start             = 1'b0;
   logic      busy;
   logic      req_mode          = MODE_LOAD;
   logic      req_first_element = 1'b0;
   word_type  req_element_value = '0;
   word_type  req_search_key    = '0;
   logic      rsp_strobe;
   logic      rsp_found;
   index_type rsp_found_index;

   int pending;
   int fail_count;
   int hit_count;

   int          load_items   = 0;
   int          search_items = 0;
   bit          gaps_on      = 1'b1;
   int unsigned cycle_count  = 0;
   word_type    loaded [$];
   int          batch [$];

   initial begin
      forever #1 clock = ~clock;
   end

   order_agnostic_binary_search_core #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_first_element(req_first_element),
      .req_element_value(req_element_value),
      .req_search_key   (req_search_key),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_found_index  (rsp_found_index)
   );

   oabs_result_checker #(
      .DEPTH(DEPTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_first_element(req_first_element),
      .req_element_value(req_element_value),
      .req_search_key   (req_search_key),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_found_index  (rsp_found_index),
      .pending          (pending),
      .fail_count       (fail_count),
      .hit_count        (hit_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d searches outstanding",
                  cycle_count, pending);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Holds the item until the core takes it, then maybe idles for a burst.
   task automatic send_item(mode_type mode, logic first, word_type value, word_type key);
      start             <= 1'b1;
      req_mode          <= mode;
      req_first_element <= first;
      req_element_value <= value;
      req_search_key    <= key;
      do @(posedge clock); while (busy !== 1'b0);
      if (mode == MODE_LOAD) load_items++;
      else search_items++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic load_word(logic first, word_type value);
      send_item(MODE_LOAD, first, value, word_type'($urandom));
      if (first) loaded.delete();
      if (loaded.size() < DEPTH) loaded.push_back(value);
   endtask

   task automatic search(word_type key);
      send_item(MODE_SEARCH, logic'($urandom_range(0, 1)), word_type'($urandom), key);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic load_array(int count, fill_kind_type kind, bit descending, bit restart);
      int base;
      base = int'($urandom);
      batch.delete();
      for (int i = 0; i < count; i++) begin
         case (kind)
            FILL_CLUSTERED: batch.push_back(base + int'($urandom_range(0, count)));
            FILL_FLAT:      batch.push_back(base);
            default:        batch.push_back(int'($urandom));
         endcase
      end
      if (kind != FILL_UNSORTED) batch.sort();
      if (kind == FILL_EXTREMES) begin
         batch[0]             = WORD_MIN;
         batch[batch.size()-1] = WORD_MAX;
      end
      if (descending) batch.reverse();
      for (int i = 0; i < count; i++) load_word(restart && i == 0, word_type'(batch[i]));
   endtask

   // Mostly keys that are present, then their neighbors, extremes and noise.
   function automatic word_type pick_key();
      int unsigned pick;
      word_type    w;
      pick = $urandom_range(0, 9);
      if (loaded.size() == 0 || pick == 9) return word_type'($urandom);
      w = loaded[$urandom_range(0, loaded.size() - 1)];
      if (pick < 6) return w;
      if (pick < 8) return ($urandom_range(0, 1) == 1) ? w + 1 : w - 1;
      case ($urandom_range(0, 2))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         default: return '0;
      endcase
   endfunction

   initial begin
      int            stop_at;
      int            count;
      fill_kind_type kind;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Nothing loaded yet.
      search('0);
      search(WORD_MAX);
      // A single word at the bottom of the range.
      load_word(1'b1, WORD_MIN);
      search(WORD_MIN);
      search(WORD_MAX);
      // Two words running downward across the whole range.
      load_word(1'b1, WORD_MAX);
      load_word(1'b0, WORD_MIN);
      search(WORD_MIN);
      search(WORD_MAX);
      search('0);
      // Equal end words fall back to an ascending search.
      load_word(1'b1, 32'sd5);
      load_word(1'b0, 32'sd5);
      load_word(1'b0, 32'sd5);
      search(32'sd5);
      search(32'sd4);
      search(32'sd6);
      // A short ascending array.
      load_word(1'b1, -32'sd3);
      load_word(1'b0, 32'sd0);
      load_word(1'b0, 32'sd7);
      load_word(1'b0, 32'sd100);
      search(32'sd100);
      search(-32'sd3);
      search(32'sd8);
      wait_for_results();

      stop_at = load_items + search_items + RANDOM_ITEMS;
      while (load_items + search_items < stop_at) begin
         gaps_on = ($urandom_range(0, 9) < 7);
         case ($urandom_range(0, 19))
            0, 1:    count = $urandom_range(25, 200);
            default: count = $urandom_range(1, 24);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = FILL_SPREAD;
            4, 5:       kind = FILL_CLUSTERED;
            6:          kind = FILL_FLAT;
            7, 8:       kind = FILL_EXTREMES;
            default:    kind = FILL_UNSORTED;
         endcase
         // Now and then the words are appended to what is already there.
         load_array(count, kind, $urandom_range(0, 1), $urandom_range(0, 11) != 0);
         repeat ($urandom_range(3, 12)) search(pick_key());
         if ($urandom_range(0, 15) == 0) wait_for_results();
      end

      // Fill the store past its end with no gaps; the extra words are dropped.
      gaps_on = 1'b0;
      load_array(DEPTH + 4, FILL_SPREAD, $urandom_range(0, 1), 1'b1);
      search(loaded[0]);
      search(loaded[DEPTH - 1]);
      for (int i = DEPTH; i < batch.size(); i++) search(word_type'(batch[i]));
      repeat (30) search(pick_key());

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d load items and %0d search items, %0d of which found their key.",
               load_items, search_items, hit_count);
      $display("Arrays were empty, flat, sorted, unsorted and a full %0d-word store.",
               DEPTH);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/oabs_pkg.sv
rtl/oabs_ram.sv
rtl/oabs_seq.sv
rtl/order_agnostic_binary_search_core.sv
tb/oabs_result_checker.sv
tb/testbench.sv
